// ----- design/cbez_pkg.sv -----
// Package for the cubic Bezier point and slope evaluator.
// Holds register indexes, reset values, field widths and default fraction bits.
// No dependencies.
`default_nettype none

package cbez_pkg;

  localparam int COORD_W             = 16;
  localparam int SLOPE_W             = 20;
  localparam int NUM_REGS            = 8;
  localparam int REG_IDX_W           = 3;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_END_X   = 3'd6,
    REG_END_Y   = 3'd7
  } reg_idx_t;

  typedef logic [COORD_W-1:0] coord_t;

  localparam coord_t REG_RESET [NUM_REGS] = '{
    16'hE000, 16'hE000, 16'hF333, 16'h2000,
    16'h0CCD, 16'h2000, 16'h2000, 16'hE000
  };

endpackage

`default_nettype wire

// ----- design/cubic_bezier_point_and_slope_top.sv -----
// Cubic Bezier evaluator: curve point (x, y) and x slope for one t per clock.
// Six-stage multiply pipeline; constants and types from cbez_pkg.
// Control points live in eight write-only configuration registers.
`default_nettype none

// One parameter value t is taken on every clock where start is high; busy is
// always low. Each result is registered through the pipeline stages and is on
// the out_ ports for one cycle with out_valid high. The pipeline stages are
// the chain of dependent steps: clamping t and forming 1-t, t squared, the
// cubic weights, the coordinate products, the weighted sum, and the final
// rounding and saturation. Write the control points only while no item is in
// flight.
module cubic_bezier_point_and_slope_top #(
  parameter int PARAM_FRAC_BITS = cbez_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [PARAM_FRAC_BITS:0]              in_param_t,
  input  logic                                  cfg_we,
  input  logic [cbez_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [cbez_pkg::COORD_W-1:0]          cfg_data,
  output logic                                  out_valid,
  output logic signed [cbez_pkg::COORD_W-1:0]   out_point_x,
  output logic signed [cbez_pkg::COORD_W-1:0]   out_point_y,
  output logic signed [cbez_pkg::SLOPE_W-1:0]   out_slope_x,
  output logic                                  out_rising
);
  import cbez_pkg::*;

  localparam int P   = PARAM_FRAC_BITS;
  localparam int TW  = P + 1;
  localparam int SQW = 2 * TW;
  localparam int WSW = TW + 1;
  localparam int KW  = COORD_W + 2;
  localparam int BPW = KW + WSW;
  localparam int BSW = BPW + 2;
  localparam int BRW = BSW - P;
  localparam int AW  = COORD_W + 5;
  localparam int DPW = AW + WSW;
  localparam int DW  = DPW + 2;
  localparam int DRW = DW - P;
  localparam int LAT = 6;

  localparam logic [TW-1:0]         ONE     = {1'b1, {P{1'b0}}};
  localparam logic [SQW-1:0]        HALF_SQ = {{(SQW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};
  localparam logic signed [BSW-1:0] HALF_B  = {{(BSW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};
  localparam logic signed [DW-1:0]  HALF_D  = {{(DW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};
  localparam logic signed [BRW-1:0] PT_HI   = {{(BRW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [BRW-1:0] PT_LO   = {{(BRW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
  localparam logic signed [DRW-1:0] SL_HI   = {{(DRW-SLOPE_W+1){1'b0}}, {(SLOPE_W-1){1'b1}}};
  localparam logic signed [DRW-1:0] SL_LO   = {{(DRW-SLOPE_W+1){1'b1}}, {(SLOPE_W-1){1'b0}}};

  function automatic logic [TW-1:0] rmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [SQW-1:0] p;
    p = SQW'(a) * SQW'(b) + HALF_SQ;
    return p[P +: TW];
  endfunction

  function automatic logic signed [AW-1:0] x3(input logic signed [AW-1:0] v);
    return v + (v <<< 1);
  endfunction

  // configuration registers
  coord_t cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= REG_RESET[i];
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // coefficients derived from the control points
  logic signed [AW-1:0] x0, x1, x2, x3v;
  logic signed [KW-1:0] kx_nxt [4];
  logic signed [KW-1:0] ky_nxt [4];
  logic signed [KW-1:0] kx_r [4];
  logic signed [KW-1:0] ky_r [4];
  logic signed [AW-1:0] a_nxt, b_nxt, c_nxt;
  logic signed [AW-1:0] a_r, b_r, c_r;

  assign x0  = AW'($signed(cfg_r[REG_START_X]));
  assign x1  = AW'($signed(cfg_r[REG_CTRL1_X]));
  assign x2  = AW'($signed(cfg_r[REG_CTRL2_X]));
  assign x3v = AW'($signed(cfg_r[REG_END_X]));

  always_comb begin
    kx_nxt[0] = KW'($signed(cfg_r[REG_START_X]));
    kx_nxt[1] = KW'(x3(x1));
    kx_nxt[2] = KW'(x3(x2));
    kx_nxt[3] = KW'($signed(cfg_r[REG_END_X]));
    ky_nxt[0] = KW'($signed(cfg_r[REG_START_Y]));
    ky_nxt[1] = KW'(x3(AW'($signed(cfg_r[REG_CTRL1_Y]))));
    ky_nxt[2] = KW'(x3(AW'($signed(cfg_r[REG_CTRL2_Y]))));
    ky_nxt[3] = KW'($signed(cfg_r[REG_END_Y]));
    a_nxt = x3(x3v) - x3(x0) + (x1 + (x1 <<< 3)) - (x2 + (x2 <<< 3));
    b_nxt = (x0 <<< 1) + (x0 <<< 2) + (x2 <<< 1) + (x2 <<< 2) - (x1 <<< 2) - (x1 <<< 3);
    c_nxt = x3(x1) - x3(x0);
  end

  always_ff @(posedge clk) begin
    kx_r <= kx_nxt;
    ky_r <= ky_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
  end

  // valid bits
  logic                 accept;
  logic [LAT-2:0]       vld_r;
  logic                 out_valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAT-3:0], accept};
      out_valid_r <= vld_r[LAT-2];
    end
  end

  // stage 1: clamp t, form 1-t
  logic [TW-1:0] t_sat;
  logic [TW-1:0] t1_r, u1_r;

  assign t_sat = (in_param_t > ONE) ? ONE : in_param_t;

  always_ff @(posedge clk) begin
    t1_r <= t_sat;
    u1_r <= ONE - t_sat;
  end

  // stage 2: squares
  logic [TW-1:0] uu2_r, tt2_r, t2_r, u2_r;

  always_ff @(posedge clk) begin
    uu2_r <= rmul(u1_r, u1_r);
    tt2_r <= rmul(t1_r, t1_r);
    t2_r  <= t1_r;
    u2_r  <= u1_r;
  end

  // stage 3: cubic weights and slope products
  logic [TW-1:0]         w3_r [4];
  logic signed [DPW-1:0] dat3_r, dbt3_r;

  always_ff @(posedge clk) begin
    w3_r[0] <= rmul(uu2_r, u2_r);
    w3_r[1] <= rmul(uu2_r, t2_r);
    w3_r[2] <= rmul(tt2_r, u2_r);
    w3_r[3] <= rmul(tt2_r, t2_r);
    dat3_r  <= DPW'(a_r) * DPW'($signed({1'b0, tt2_r}));
    dbt3_r  <= DPW'(b_r) * DPW'($signed({1'b0, t2_r}));
  end

  // stage 4: coordinate products, exact slope
  logic signed [BPW-1:0] px4_r [4];
  logic signed [BPW-1:0] py4_r [4];
  logic signed [DW-1:0]  d4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      px4_r[i] <= BPW'(kx_r[i]) * BPW'($signed({1'b0, w3_r[i]}));
      py4_r[i] <= BPW'(ky_r[i]) * BPW'($signed({1'b0, w3_r[i]}));
    end
    d4_r <= DW'(dat3_r) + DW'(dbt3_r) + (DW'(c_r) <<< P);
  end

  // stage 5: sums, slope rounding and saturation
  logic signed [BSW-1:0] sumx5_r, sumy5_r;
  logic signed [DW-1:0]  d_rnd;
  logic signed [DRW-1:0] d_sh;
  logic signed [SLOPE_W-1:0] slope_nxt;
  logic signed [SLOPE_W-1:0] slope5_r;
  logic                      rise5_r;

  always_comb begin
    d_rnd = (d4_r + HALF_D) >>> P;
    d_sh  = d_rnd[DRW-1:0];
    priority if (d_sh > SL_HI) begin
      slope_nxt = SL_HI[SLOPE_W-1:0];
    end else if (d_sh < SL_LO) begin
      slope_nxt = SL_LO[SLOPE_W-1:0];
    end else begin
      slope_nxt = d_sh[SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sumx5_r  <= BSW'(px4_r[0]) + BSW'(px4_r[1]) + BSW'(px4_r[2]) + BSW'(px4_r[3]);
    sumy5_r  <= BSW'(py4_r[0]) + BSW'(py4_r[1]) + BSW'(py4_r[2]) + BSW'(py4_r[3]);
    slope5_r <= slope_nxt;
    rise5_r  <= !d4_r[DW-1];
  end

  // stage 6: point rounding and saturation, output registers
  logic signed [BSW-1:0]     sx_rnd, sy_rnd;
  logic signed [BRW-1:0]     sx_sh, sy_sh;
  logic signed [COORD_W-1:0] px_nxt, py_nxt;
  logic signed [COORD_W-1:0] point_x_r, point_y_r;
  logic signed [SLOPE_W-1:0] slope_x_r;
  logic                      rising_r;

  always_comb begin
    sx_rnd = (sumx5_r + HALF_B) >>> P;
    sy_rnd = (sumy5_r + HALF_B) >>> P;
    sx_sh  = sx_rnd[BRW-1:0];
    sy_sh  = sy_rnd[BRW-1:0];
    priority if (sx_sh > PT_HI) begin
      px_nxt = PT_HI[COORD_W-1:0];
    end else if (sx_sh < PT_LO) begin
      px_nxt = PT_LO[COORD_W-1:0];
    end else begin
      px_nxt = sx_sh[COORD_W-1:0];
    end
    priority if (sy_sh > PT_HI) begin
      py_nxt = PT_HI[COORD_W-1:0];
    end else if (sy_sh < PT_LO) begin
      py_nxt = PT_LO[COORD_W-1:0];
    end else begin
      py_nxt = sy_sh[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    point_x_r <= px_nxt;
    point_y_r <= py_nxt;
    slope_x_r <= slope5_r;
    rising_r  <= rise5_r;
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = point_x_r;
  assign out_point_y = point_y_r;
  assign out_slope_x = slope_x_r;
  assign out_rising  = rising_r;

  // assertions
  a_no_valid_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_valid_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching input transfer");

  a_neg_slope_not_rising: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_slope_x[SLOPE_W-1]) |-> !out_rising)
    else $error("negative slope flagged as rising");

endmodule

`default_nettype wire

// ----- dv/tb_cubic_bezier_point_and_slope_top.sv -----
// Testbench for cubic_bezier_point_and_slope_top: queue-fed driver, clocked monitor,
// in-bench fixed-point predictor of point, slope and rising flag over several control sets.
// Depends on cbez_pkg and the top module only.
module tb_cubic_bezier_point_and_slope_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbez_pkg::*;

  localparam int     P      = PARAM_FRAC_BITS_DEF;
  localparam longint ONE    = longint'(1) << P;
  localparam longint HALF   = longint'(1) << (P - 1);
  localparam longint PT_MIN = -32768;
  localparam longint PT_MAX = 32767;
  localparam longint SL_MIN = -524288;
  localparam longint SL_MAX = 524287;

  typedef struct {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [SLOPE_W-1:0] slope_x;
    logic                      rising;
  } bez_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [P:0]             in_param_t = '0;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_W-1:0]     cfg_data = '0;
  logic                   out_valid;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [SLOPE_W-1:0] out_slope_x;
  logic                   out_rising;

  coord_t       ctrl_pts [NUM_REGS];
  logic [P:0]   param_q [$];
  bez_result_t  curve_q [$];
  int           send_idle_pct = 9;
  int           err_count = 0;

  cubic_bezier_point_and_slope_top #(.PARAM_FRAC_BITS(P)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_param_t  (in_param_t),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_slope_x (out_slope_x),
    .out_rising  (out_rising)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] blend_axis(
    coord_t c0, coord_t c1, coord_t c2, coord_t c3,
    longint w0, longint w1, longint w2, longint w3);
    longint sum;
    longint v;
    sum = longint'($signed(c0)) * w0 + 3 * longint'($signed(c1)) * w1
        + 3 * longint'($signed(c2)) * w2 + longint'($signed(c3)) * w3;
    v = clamp_to((sum + HALF) >>> P, PT_MIN, PT_MAX);
    return v[COORD_W-1:0];
  endfunction

  function automatic bez_result_t predict_bezier(logic [P:0] t_raw);
    longint t, u, uu, tt, w0, w1, w2, w3;
    longint x0, x1, x2, x3, a, b, c, d, sl;
    bez_result_t r;
    t = longint'(t_raw);
    if (t > ONE) t = ONE;
    u  = ONE - t;
    uu = (u * u + HALF) >> P;
    tt = (t * t + HALF) >> P;
    w0 = (uu * u + HALF) >> P;
    w1 = (uu * t + HALF) >> P;
    w2 = (tt * u + HALF) >> P;
    w3 = (tt * t + HALF) >> P;
    r.point_x = blend_axis(ctrl_pts[REG_START_X], ctrl_pts[REG_CTRL1_X],
                           ctrl_pts[REG_CTRL2_X], ctrl_pts[REG_END_X], w0, w1, w2, w3);
    r.point_y = blend_axis(ctrl_pts[REG_START_Y], ctrl_pts[REG_CTRL1_Y],
                           ctrl_pts[REG_CTRL2_Y], ctrl_pts[REG_END_Y], w0, w1, w2, w3);
    x0 = longint'($signed(ctrl_pts[REG_START_X]));
    x1 = longint'($signed(ctrl_pts[REG_CTRL1_X]));
    x2 = longint'($signed(ctrl_pts[REG_CTRL2_X]));
    x3 = longint'($signed(ctrl_pts[REG_END_X]));
    a  = -3 * x0 + 9 * x1 - 9 * x2 + 3 * x3;
    b  = 6 * x0 - 12 * x1 + 6 * x2;
    c  = -3 * x0 + 3 * x1;
    d  = a * tt + b * t + c * ONE;
    sl = clamp_to((d + HALF) >>> P, SL_MIN, SL_MAX);
    r.slope_x = sl[SLOPE_W-1:0];
    r.rising  = (d >= 0);
    return r;
  endfunction

  function automatic logic [P:0] pick_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return (P+1)'(ONE);
      2:       return (P+1)'($urandom_range(32'(ONE + 1), 32'(2 * ONE - 1)));
      3:       return (P+1)'($urandom_range(0, 31));
      4:       return (P+1)'($urandom_range(32'(ONE - 31), 32'(ONE)));
      default: return (P+1)'($urandom_range(0, 32'(ONE)));
    endcase
  endfunction

  // driver: one transfer per accepted start, expectation captured at that edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        curve_q.push_back(predict_bezier(in_param_t));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (param_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start      <= 1'b1;
        in_param_t <= param_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bez_result_t e;
    if (rst_n && out_valid) begin
      if (curve_q.size() == 0) begin
        $error("result with no transfer pending");
        err_count++;
      end else begin
        e = curve_q.pop_front();
        if (out_point_x !== e.point_x) begin
          $error("point_x expected %0d got %0d", e.point_x, out_point_x);
          err_count++;
        end
        if (out_point_y !== e.point_y) begin
          $error("point_y expected %0d got %0d", e.point_y, out_point_y);
          err_count++;
        end
        if (out_slope_x !== e.slope_x) begin
          $error("slope_x expected %0d got %0d", e.slope_x, out_slope_x);
          err_count++;
        end
        if (out_rising !== e.rising) begin
          $error("rising expected %0d got %0d", e.rising, out_rising);
          err_count++;
        end
      end
    end
  end

  task automatic wait_drain();
    do @(negedge clk);
    while (param_q.size() != 0 || start || curve_q.size() != 0);
  endtask

  task automatic load_points(input coord_t vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_we      <= 1'b1;
      cfg_index   <= reg_idx_t'(i);
      cfg_data    <= vals[i];
      ctrl_pts[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    coord_t     pts [NUM_REGS];
    logic [P:0] directed [];
    directed = '{
      17'h00000, 17'h10000, 17'h00001, 17'h0FFFF, 17'h08000, 17'h04000, 17'h0C000,
      17'h10001, 17'h1FFFF, 17'h15555, 17'h0AAAA, 17'h05555, 17'h1AAAA, 17'h00002,
      17'h0FFFE, 17'h12345
    };
    ctrl_pts = REG_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) param_q.push_back(directed[i]);

    for (int ph = 0; ph < 9; ph++) begin
      wait_drain();
      send_idle_pct = (ph < 3) ? 9 : (ph < 6) ? 69 : 0;
      case (ph)
        0: foreach (pts[i]) pts[i] = 16'h7FFF;
        1: foreach (pts[i]) pts[i] = 16'h8000;
        2, 3: begin
          // zig-zag control polygon drives the x slope to its largest magnitude
          pts[REG_START_X] = (ph == 2) ? 16'h8000 : 16'h7FFF;
          pts[REG_CTRL1_X] = (ph == 2) ? 16'h7FFF : 16'h8000;
          pts[REG_CTRL2_X] = (ph == 2) ? 16'h8000 : 16'h7FFF;
          pts[REG_END_X]   = (ph == 2) ? 16'h7FFF : 16'h8000;
          pts[REG_START_Y] = 16'h7FFF;
          pts[REG_CTRL1_Y] = 16'h8000;
          pts[REG_CTRL2_Y] = 16'h7FFF;
          pts[REG_END_Y]   = 16'h8000;
        end
        8:       pts = REG_RESET;
        default: foreach (pts[i]) pts[i] = coord_t'($urandom());
      endcase
      load_points(pts);
      repeat (110) param_q.push_back(pick_param());
    end

    wait_drain();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- cubic_bezier_point_and_slope_top.f -----
design/cbez_pkg.sv
design/cubic_bezier_point_and_slope_top.sv
dv/tb_cubic_bezier_point_and_slope_top.sv
